/* design/spc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spc_pkg: shared types and constants for the sensor PROM CRC4 checker
// Holds the CRC feedback, word masks and the result record.
// ---------------------------------------------------------------------------
package spc_pkg;

   localparam int unsigned WORD_W = 16;
   localparam int unsigned POS_W  = 3;
   localparam int unsigned NIB_W  = 4;

   localparam logic [WORD_W-1:0] CRC_FEEDBACK   = 16'h3000;
   localparam logic [WORD_W-1:0] HIGH_BYTE_MASK = 16'hFF00;
   localparam logic [WORD_W-1:0] WORD_ONES      = 16'hFFFF;
   localparam logic [WORD_W-1:0] WORD_ZERO      = 16'h0000;
   localparam logic [POS_W-1:0]  LAST_POSITION  = 3'd7;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [NIB_W-1:0]  nibble_type;

   typedef struct packed {
      nibble_type stored_crc;
      nibble_type computed_crc;
      logic       signal_present;
      logic       prom_valid;
   } result_type;

endpackage

/* design/spc_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spc_req_if / spc_rsp_if: valid-ready channels of the CRC4 checker
// One carries PROM words in, the other carries check results out.
// ---------------------------------------------------------------------------
interface spc_req_if;
   logic              valid;
   logic              ready;
   spc_pkg::word_type prom_word;

   modport source (output valid, output prom_word, input ready);
   modport sink   (input valid, input prom_word, output ready);
endinterface

interface spc_rsp_if;
   logic                valid;
   logic                ready;
   spc_pkg::nibble_type stored_crc;
   spc_pkg::nibble_type computed_crc;
   logic                signal_present;
   logic                prom_valid;

   modport source (output valid, output stored_crc, output computed_crc,
                   output signal_present, output prom_valid, input ready);
   modport sink   (input valid, input stored_crc, input computed_crc,
                   input signal_present, input prom_valid, output ready);
endinterface

/* design/spc_crc_step.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spc_crc_step: absorb one PROM word into the CRC4 remainder
// High byte then low byte, eight MSB-first shifts each, feedback 0x3000.
// ---------------------------------------------------------------------------
module spc_crc_step (
   input  spc_pkg::word_type rem_cur,
   input  spc_pkg::word_type word,
   input  logic              last,
   output spc_pkg::word_type rem_next
);

   spc_pkg::word_type crc_word;
   spc_pkg::word_type rem_hi;

   // drop the low byte of the final word; it carries the CRC itself
   assign crc_word = last ? (word & spc_pkg::HIGH_BYTE_MASK) : word;

   always_comb begin
      spc_pkg::word_type r;
      r = rem_cur ^ {8'h00, crc_word[15:8]};
      for (int k = 0; k < 8; k++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ spc_pkg::CRC_FEEDBACK;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      rem_hi = r;
   end

   always_comb begin
      spc_pkg::word_type r;
      r = rem_hi ^ {8'h00, crc_word[7:0]};
      for (int k = 0; k < 8; k++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ spc_pkg::CRC_FEEDBACK;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      rem_next = r;
   end

endmodule

/* design/sensor_prom_crc4_check.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sensor_prom_crc4_check: CRC4 and bus-sanity check of an 8-word sensor PROM
// Takes a word per cycle unless a result stalls; emits one after every eighth word.
// ---------------------------------------------------------------------------
// Timing: an eighth word is first held in the input register; its result is
//   then registered in the result register, once that register is free.
// Throughput: one word per cycle unless the last word waits on an unread result;
//   the remainder update is a single pass of sixteen unrolled shift steps.
// Reset: synchronous; clears the position, remainder and OR accumulator,
//   sets the AND accumulator to all ones and empties both registers.
module sensor_prom_crc4_check (
   input  logic          clock,
   input  logic          reset,
   spc_req_if.sink       req_if,
   spc_rsp_if.source     rsp_if
);

   logic                s1_valid_ff, s1_valid_in;
   spc_pkg::word_type   s1_word_ff;
   spc_pkg::pos_type    pos_ff, pos_in;
   spc_pkg::word_type   rem_ff, rem_in;
   spc_pkg::word_type   or_ff, or_in;
   spc_pkg::word_type   and_ff, and_in;
   logic                rsp_valid_ff, rsp_valid_in;
   spc_pkg::result_type res_ff, res_in;

   logic                s1_last;
   logic                s1_advance;
   logic                req_take;
   spc_pkg::word_type   rem_next;
   spc_pkg::word_type   or_next;
   spc_pkg::word_type   and_next;
   logic                present;

   assign s1_last    = (pos_ff == spc_pkg::LAST_POSITION);
   // a word that makes no result never waits on the output side
   assign s1_advance = s1_valid_ff && (!s1_last || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign req_take   = req_if.valid && req_if.ready;

   spc_crc_step u_crc (
      .rem_cur  (rem_ff),
      .word     (s1_word_ff),
      .last     (s1_last),
      .rem_next (rem_next)
   );

   assign or_next  = or_ff | s1_word_ff;
   assign and_next = and_ff & s1_word_ff;
   assign present  = (or_next != spc_pkg::WORD_ZERO) && (and_next != spc_pkg::WORD_ONES);

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      or_in        = or_ff;
      and_in       = and_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_if.ready);
      res_in       = res_ff;
      if (s1_advance) begin
         if (s1_last) begin
            // close the set: emit and start over
            pos_in                = '0;
            rem_in                = spc_pkg::WORD_ZERO;
            or_in                 = spc_pkg::WORD_ZERO;
            and_in                = spc_pkg::WORD_ONES;
            rsp_valid_in          = 1'b1;
            res_in.stored_crc     = s1_word_ff[3:0];
            res_in.computed_crc   = rem_next[15:12];
            res_in.signal_present = present;
            res_in.prom_valid     = present && (s1_word_ff[3:0] == rem_next[15:12]);
         end else begin
            pos_in = pos_ff + spc_pkg::pos_type'(1);
            rem_in = rem_next;
            or_in  = or_next;
            and_in = and_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         rem_ff       <= spc_pkg::WORD_ZERO;
         or_ff        <= spc_pkg::WORD_ZERO;
         and_ff       <= spc_pkg::WORD_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         pos_ff       <= pos_in;
         rem_ff       <= rem_in;
         or_ff        <= or_in;
         and_ff       <= and_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_if.prom_word;
      end
      res_ff <= res_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.stored_crc     = res_ff.stored_crc;
   assign rsp_if.computed_crc   = res_ff.computed_crc;
   assign rsp_if.signal_present = res_ff.signal_present;
   assign rsp_if.prom_valid     = res_ff.prom_valid;

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last |=> rsp_valid_ff)
      else $error("last word of a set did not produce a transaction");

   a_set_clears: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last |=> pos_ff == '0 && rem_ff == spc_pkg::WORD_ZERO
                                && or_ff == spc_pkg::WORD_ZERO
                                && and_ff == spc_pkg::WORD_ONES)
      else $error("state not cleared after end of set");

   a_valid_needs_signal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !res_ff.prom_valid || res_ff.signal_present)
      else $error("prom_valid set without signal present");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_if.ready)
      else $error("empty input register refused a transaction");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !s1_last |=> pos_ff == $past(pos_ff) + spc_pkg::pos_type'(1))
      else $error("word position did not advance");

endmodule
